FILE: rtl/trl_pkg.sv
// Shared types, sizes, breakpoint tables and limits for the thermistor/RTD linearizer.
// Depends on nothing; every other rtl file refers to it by scoped names.
`default_nettype none

package trl_pkg;

    // Word fields
    localparam int CODE_W = 4;
    localparam int RAW_W  = 12;
    localparam int TEMP_W = 20;
    localparam int STAT_W = 2;

    // Stream widths: fields padded up to whole bytes
    localparam int S_TDATA_W = ((RAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TEMP_W + 7) / 8) * 8;

    // Table geometry
    localparam int THERM_SEGMENTS = 16;
    localparam int RTD_SEGMENTS   = 50;
    localparam int THERM_TABLES   = 4;
    localparam int MAX_SEGMENTS   = (RTD_SEGMENTS > THERM_SEGMENTS) ?
                                    RTD_SEGMENTS : THERM_SEGMENTS;
    localparam int ROW_W = $clog2(THERM_TABLES);
    localparam int TI_W  = $clog2(THERM_SEGMENTS + 1);
    localparam int RI_W  = $clog2(RTD_SEGMENTS + 1);
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    // Interpolation arithmetic
    localparam int STEP_SCALE  = 100;
    localparam int QUO_W       = $clog2(STEP_SCALE + 1);
    localparam int NUM_W       = RAW_W + QUO_W;
    localparam int POS_W       = $clog2(MAX_SEGMENTS * STEP_SCALE + 1);
    localparam int UNIT_W      = 8;
    localparam int PROD_W      = UNIT_W + POS_W;
    // deg_per_seg is a multiple of 125 mdeg: deg*pos/100 == units*pos*5/4
    localparam int GRAIN_NUM   = 5;
    localparam int GRAIN_SHIFT = 2;
    localparam int SCL_W       = PROD_W + 3;
    localparam int SUM_W       = SCL_W + 1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_LOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_HIGH = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

    // Sensor range codes
    localparam logic [CODE_W-1:0] CODE_THERM_FIRST = 4'd1;
    localparam logic [CODE_W-1:0] CODE_THERM_LAST  = 4'd8;
    localparam logic [CODE_W-1:0] CODE_RTD_C       = 4'd9;
    localparam logic [CODE_W-1:0] CODE_RTD_F       = 4'd10;

    // Overall output range
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -20'sd200000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 20'sd302000;

    // Thermistor breakpoints, descending ADC counts
    localparam logic [RAW_W-1:0] THERM_TAB [THERM_TABLES][THERM_SEGMENTS+1] = '{
        '{3728, 3376, 2864, 2256, 1648, 1136, 768, 512, 336, 224, 160, 112,
          80, 64, 48, 32, 16},
        '{3975, 3879, 3720, 3476, 3110, 2747, 2303, 1864, 1464, 1140, 866, 660,
          516, 393, 312, 250, 203},
        '{3728, 3440, 3040, 2560, 2032, 1536, 1120, 800, 560, 400, 288, 208,
          144, 112, 80, 64, 48},
        '{3932, 3816, 3640, 3394, 3075, 2700, 2289, 1881, 1512, 1196, 950, 738,
          577, 456, 365, 306, 248}
    };

    // PT1000 breakpoints, ascending ADC counts
    localparam logic [RAW_W-1:0] RTD_TAB [RTD_SEGMENTS+1] = '{
        461, 537, 609, 683, 758, 829, 900, 971, 1043, 1113,
        1183, 1256, 1327, 1392, 1464, 1532, 1601, 1668, 1739, 1805,
        1872, 1940, 2006, 2076, 2140, 2209, 2276, 2344, 2407, 2474,
        2540, 2607, 2672, 2737, 2804, 2866, 2934, 2997, 3058, 3126,
        3188, 3250, 3315, 3382, 3441, 3504, 3566, 3629, 3693, 3752,
        3813
    };

    // Per-code tables, indexed by the raw code; invalid codes hold zero.
    // Degrees per segment in units of 125 mdeg.
    localparam logic [UNIT_W-1:0] DEG_UNITS [16] = '{
        0, 95, 171, 80, 144, 80, 144, 80, 144, 80, 144, 0, 0, 0, 0, 0
    };

    localparam logic signed [TEMP_W-1:0] LIM_LO [16] = '{
        0, -40000, -40000, -40000, -40000, -40000, -40000, -40000, -40000,
        -200000, -200000, 0, 0, 0, 0, 0
    };

    localparam logic signed [TEMP_W-1:0] LIM_HI [16] = '{
        0, 150000, 302000, 120000, 248000, 120000, 248000, 120000, 248000,
        300000, 300000, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [STAT_W-1:0] status;
        logic [SEG_W-1:0]  seg;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [RAW_W-1:0] delta;
        logic [RAW_W-1:0] span;
    } seg_word_t;

    typedef struct packed {
        side_t            side;
        logic [QUO_W-1:0] quo;
    } quo_word_t;

    function automatic logic is_therm(input logic [CODE_W-1:0] code);
        return (code >= CODE_THERM_FIRST) && (code <= CODE_THERM_LAST);
    endfunction

    function automatic logic is_rtd(input logic [CODE_W-1:0] code);
        return (code == CODE_RTD_C) || (code == CODE_RTD_F);
    endfunction

    // Codes 1,2 -> table 0; 3,4 -> 1; 5,6 -> 2; 7,8 -> 3
    function automatic logic [ROW_W-1:0] therm_row(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] cm1;
        cm1 = code - CODE_THERM_FIRST;
        return cm1[ROW_W:1];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/trl_seg_find.sv
// Two pipeline stages: breakpoint compares to pick the segment, then table fetch for
// distance and span within that segment. Uses trl_pkg.
`default_nettype none

module trl_seg_find (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [trl_pkg::CODE_W-1:0] in_code,
    input  logic [trl_pkg::RAW_W-1:0]  in_raw,
    output logic                     out_valid,
    input  logic                     out_ready,
    output trl_pkg::seg_word_t       out_word
);

    // Stage A: compares
    logic                          a_valid_reg;
    logic [trl_pkg::CODE_W-1:0]    a_code_reg;
    logic [trl_pkg::RAW_W-1:0]     a_raw_reg;
    logic [trl_pkg::STAT_W-1:0]    a_status_reg;
    logic [trl_pkg::SEG_W-1:0]     a_seg_reg;
    logic [trl_pkg::STAT_W-1:0]    a_status_next;
    logic [trl_pkg::SEG_W-1:0]     a_seg_next;
    logic                          a_ready;

    // Stage B: fetch
    logic                          b_valid_reg;
    trl_pkg::seg_word_t            b_word_reg;
    trl_pkg::seg_word_t            b_word_next;
    logic                          b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        logic [trl_pkg::ROW_W-1:0] row;
        logic [trl_pkg::SEG_W-1:0] t_seg;
        logic [trl_pkg::SEG_W-1:0] r_seg;
        row   = trl_pkg::therm_row(in_code);
        t_seg = '0;
        r_seg = '0;
        // descending table: last breakpoint still above the sample
        for (int k = 1; k < trl_pkg::THERM_SEGMENTS; k++) begin
            if (in_raw < trl_pkg::THERM_TAB[row][k]) begin
                t_seg = trl_pkg::SEG_W'(k);
            end
        end
        // ascending table: last breakpoint still below the sample
        for (int k = 1; k < trl_pkg::RTD_SEGMENTS; k++) begin
            if (in_raw > trl_pkg::RTD_TAB[k]) begin
                r_seg = trl_pkg::SEG_W'(k);
            end
        end
        a_seg_next    = '0;
        a_status_next = trl_pkg::ST_OK;
        if (trl_pkg::is_therm(in_code)) begin
            if (in_raw <= trl_pkg::THERM_TAB[row][trl_pkg::THERM_SEGMENTS]) begin
                a_status_next = trl_pkg::ST_HIGH;
            end else if (in_raw >= trl_pkg::THERM_TAB[row][0]) begin
                a_status_next = trl_pkg::ST_LOW;
            end else begin
                a_seg_next = t_seg;
            end
        end else if (trl_pkg::is_rtd(in_code)) begin
            if (in_raw <= trl_pkg::RTD_TAB[0]) begin
                a_status_next = trl_pkg::ST_LOW;
            end else if (in_raw >= trl_pkg::RTD_TAB[trl_pkg::RTD_SEGMENTS]) begin
                a_status_next = trl_pkg::ST_HIGH;
            end else begin
                a_seg_next = r_seg;
            end
        end else begin
            a_status_next = trl_pkg::ST_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_code_reg   <= in_code;
            a_raw_reg    <= in_raw;
            a_status_reg <= a_status_next;
            a_seg_reg    <= a_seg_next;
        end
    end

    always_comb begin
        logic [trl_pkg::ROW_W-1:0] row;
        logic [trl_pkg::TI_W-1:0]  ti;
        logic [trl_pkg::TI_W-1:0]  ti1;
        logic [trl_pkg::RI_W-1:0]  ri;
        logic [trl_pkg::RI_W-1:0]  ri1;
        logic [trl_pkg::RAW_W-1:0] p0;
        logic [trl_pkg::RAW_W-1:0] p1;
        row = trl_pkg::therm_row(a_code_reg);
        ti  = a_seg_reg[trl_pkg::TI_W-1:0];
        ti1 = ti + 1'b1;
        ri  = a_seg_reg[trl_pkg::RI_W-1:0];
        ri1 = ri + 1'b1;
        b_word_next.side.code   = a_code_reg;
        b_word_next.side.status = a_status_reg;
        b_word_next.side.seg    = a_seg_reg;
        if (trl_pkg::is_rtd(a_code_reg)) begin
            p0 = trl_pkg::RTD_TAB[ri];
            p1 = trl_pkg::RTD_TAB[ri1];
            b_word_next.delta = a_raw_reg - p0;
            b_word_next.span  = p1 - p0;
        end else begin
            p0 = trl_pkg::THERM_TAB[row][ti];
            p1 = trl_pkg::THERM_TAB[row][ti1];
            b_word_next.delta = p0 - a_raw_reg;
            b_word_next.span  = p0 - p1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

`default_nettype wire

FILE: rtl/trl_div.sv
// Pipelined restoring divider: (delta*100)/span, one quotient bit per stage.
// Carries the side fields alongside. Uses trl_pkg.
`default_nettype none

module trl_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  trl_pkg::seg_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output trl_pkg::quo_word_t out_word
);

    localparam int NST = trl_pkg::QUO_W;

    logic                          v_reg    [0:NST];
    logic [trl_pkg::NUM_W-1:0]     rem_reg  [0:NST];
    logic [trl_pkg::RAW_W-1:0]     span_reg [0:NST];
    logic [trl_pkg::QUO_W-1:0]     q_reg    [0:NST];
    logic                          zero_reg [0:NST];
    trl_pkg::side_t                side_reg [0:NST];
    logic                          rdy      [0:NST+1];
    logic [trl_pkg::NUM_W-1:0]     trial    [1:NST];
    logic                          take     [1:NST];

    always_comb begin
        rdy[NST+1] = out_ready;
        for (int k = NST; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    // trial divisor for stage j is span shifted to quotient bit NST-j
    always_comb begin
        for (int j = 1; j <= NST; j++) begin
            trial[j] = trl_pkg::NUM_W'(span_reg[j-1]) << (NST - j);
            take[j]  = rem_reg[j-1] >= trial[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int j = 1; j <= NST; j++) begin
                if (rdy[j]) begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            rem_reg[0]  <= trl_pkg::NUM_W'(in_word.delta) *
                           trl_pkg::NUM_W'(trl_pkg::STEP_SCALE);
            span_reg[0] <= in_word.span;
            q_reg[0]    <= '0;
            zero_reg[0] <= (in_word.span == '0);
            side_reg[0] <= in_word.side;
        end
        for (int j = 1; j <= NST; j++) begin
            if (rdy[j] && v_reg[j-1]) begin
                rem_reg[j]  <= take[j] ? (rem_reg[j-1] - trial[j]) : rem_reg[j-1];
                q_reg[j]    <= q_reg[j-1] |
                               (take[j] ? (trl_pkg::QUO_W'(1) << (NST - j)) : '0);
                span_reg[j] <= span_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // zero span: position is the segment start
    assign out_valid     = v_reg[NST];
    assign out_word.side = side_reg[NST];
    assign out_word.quo  = zero_reg[NST] ? '0 : q_reg[NST];

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_word.side.status == trl_pkg::ST_OK)
        |-> (out_word.quo <= trl_pkg::QUO_W'(trl_pkg::STEP_SCALE)))
        else $error("divider quotient above step scale");

endmodule

`default_nettype wire

FILE: rtl/trl_scale.sv
// Three stages: segment position, scale by degrees per segment, add offset and clamp.
// Last stage is the output register. Uses trl_pkg.
`default_nettype none

module trl_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  trl_pkg::quo_word_t           in_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [trl_pkg::TEMP_W-1:0] out_temp,
    output logic [trl_pkg::STAT_W-1:0]   out_status
);

    logic                        p_valid_reg;
    trl_pkg::side_t              p_side_reg;
    logic [trl_pkg::POS_W-1:0]   p_pos_reg;
    logic                        m_valid_reg;
    trl_pkg::side_t              m_side_reg;
    logic [trl_pkg::PROD_W-1:0]  m_prod_reg;
    logic                        o_valid_reg;
    logic signed [trl_pkg::TEMP_W-1:0] o_temp_reg;
    logic signed [trl_pkg::TEMP_W-1:0] o_temp_next;
    logic [trl_pkg::STAT_W-1:0]  o_status_reg;
    logic [trl_pkg::STAT_W-1:0]  o_status_next;
    logic                        p_ready;
    logic                        m_ready;
    logic                        o_ready;

    assign o_ready  = !o_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign p_ready  = !p_valid_reg || m_ready;
    assign in_ready = p_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= in_valid;
            end
            if (m_ready) begin
                m_valid_reg <= p_valid_reg;
            end
            if (o_ready) begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    // pos = seg*100 + quotient
    always_ff @(posedge aclk) begin
        if (p_ready && in_valid) begin
            p_side_reg <= in_word.side;
            p_pos_reg  <= trl_pkg::POS_W'(in_word.side.seg) *
                          trl_pkg::POS_W'(trl_pkg::STEP_SCALE) +
                          trl_pkg::POS_W'(in_word.quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready && p_valid_reg) begin
            m_side_reg <= p_side_reg;
            m_prod_reg <= trl_pkg::PROD_W'(trl_pkg::DEG_UNITS[p_side_reg.code]) *
                          trl_pkg::PROD_W'(p_pos_reg);
        end
    end

    always_comb begin
        logic [trl_pkg::SCL_W-1:0]        scaled;
        logic signed [trl_pkg::SUM_W-1:0] lo_ext;
        logic signed [trl_pkg::SUM_W-1:0] hi_ext;
        logic signed [trl_pkg::SUM_W-1:0] sum;
        logic signed [trl_pkg::TEMP_W-1:0] lo;
        logic signed [trl_pkg::TEMP_W-1:0] hi;
        lo     = trl_pkg::LIM_LO[m_side_reg.code];
        hi     = trl_pkg::LIM_HI[m_side_reg.code];
        scaled = (trl_pkg::SCL_W'(m_prod_reg) * trl_pkg::SCL_W'(trl_pkg::GRAIN_NUM))
                 >> trl_pkg::GRAIN_SHIFT;
        lo_ext = trl_pkg::SUM_W'(lo);
        hi_ext = trl_pkg::SUM_W'(hi);
        sum    = $signed({1'b0, scaled}) + lo_ext;
        o_temp_next   = sum[trl_pkg::TEMP_W-1:0];
        o_status_next = m_side_reg.status;
        case (m_side_reg.status)
            trl_pkg::ST_BAD: begin
                o_temp_next = '0;
            end
            trl_pkg::ST_LOW: begin
                o_temp_next = lo;
            end
            trl_pkg::ST_HIGH: begin
                o_temp_next = hi;
            end
            default: begin
                if (sum > hi_ext) begin
                    o_temp_next   = hi;
                    o_status_next = trl_pkg::ST_HIGH;
                end else if (sum < lo_ext) begin
                    o_temp_next   = lo;
                    o_status_next = trl_pkg::ST_LOW;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (o_ready && m_valid_reg) begin
            o_temp_reg   <= o_temp_next;
            o_status_reg <= o_status_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_temp   = o_temp_reg;
    assign out_status = o_status_reg;

endmodule

`default_nettype wire

FILE: rtl/thermistor_rtd_linearizer_top.sv
// Top level of the thermistor/PT1000 linearizer: segment search, divider, scaling.
// Depends on trl_pkg, trl_seg_find, trl_div, trl_scale.
//
//  channel  | dir | tdata               | tuser
//  ---------+-----+---------------------+-----------------------
//  s_       | in  | [11:0] raw_sample   | [3:0] sensor_range
//  m_       | out | [19:0] temperature  | [1:0] status
//
// One word in and one word out per cycle, sustained while m_ does not stall. Stages:
// 2 for compare and table fetch, 1 for dist*100, 7 divider stages (one
// quotient bit each), 3 for position, scale and offset/clamp.
// Every stage has its own valid bit and ready; a stall on m_ fills bubbles
// first and only back-pressures s_ once every stage holds a word.
// aresetn is synchronous and clears the valid bits only.
`default_nettype none

module thermistor_rtd_linearizer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trl_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] raw_sample
    input  logic [trl_pkg::CODE_W-1:0]      s_tuser,   // [3:0] sensor_range
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trl_pkg::M_TDATA_W-1:0]   m_tdata,   // [19:0] temperature
    output logic [trl_pkg::STAT_W-1:0]      m_tuser    // [1:0] status
);

    logic               sf_valid;
    logic               sf_ready;
    trl_pkg::seg_word_t sf_word;
    logic               dv_valid;
    logic               dv_ready;
    trl_pkg::quo_word_t dv_word;
    logic signed [trl_pkg::TEMP_W-1:0] temp;

    // Stages 1-2: pick segment, fetch its endpoints
    trl_seg_find u_seg_find (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_code   (s_tuser),
        .in_raw    (s_tdata[trl_pkg::RAW_W-1:0]),
        .out_valid (sf_valid),
        .out_ready (sf_ready),
        .out_word  (sf_word)
    );

    // Stages 3-10: fractional position within the segment, 0..100
    trl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sf_valid),
        .in_ready  (sf_ready),
        .in_word   (sf_word),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_word  (dv_word)
    );

    // Stages 11-13: temperature, saturation, output register
    trl_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dv_valid),
        .in_ready   (dv_ready),
        .in_word    (dv_word),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_temp   (temp),
        .out_status (m_tuser)
    );

    assign m_tdata = {{(trl_pkg::M_TDATA_W - trl_pkg::TEMP_W){1'b0}}, temp};

    // invalid code always reads zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == trl_pkg::ST_BAD) |-> (temp == '0))
        else $error("invalid range word with nonzero temperature");

    // any valid word stays inside the overall sensor span
    a_temp_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != trl_pkg::ST_BAD)
        |-> (temp >= trl_pkg::TEMP_MIN && temp <= trl_pkg::TEMP_MAX))
        else $error("temperature outside sensor span");

    // empty output stage means the pipe can take a word
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output stage empty");

endmodule

`default_nettype wire
